// File: hw/rtl/periodic_sample_scheduler_defines.svh
// ---------------------------------------------------------------------------
// Periodic sample scheduler assertion macros
// Concurrent assertion shorthands, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_SAMPLE_SCHEDULER_DEFINES_SVH
`define PERIODIC_SAMPLE_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("periodic sample scheduler assertion failed");

// Next-cycle implication.
`define PSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("periodic sample scheduler assertion failed");

`endif

// File: hw/rtl/pss_pkg.sv
// ---------------------------------------------------------------------------
// Periodic sample scheduler package
// Transaction types, operation and status codes, and shared control types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pss_pkg;

    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int Q_DEPTH = 2;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic [2:0]        operation;
        logic [DATA_W-1:0] tick_value;
        logic [DATA_W-1:0] entry_phase;
        logic [DATA_W-1:0] entry_period;
        logic [DATA_W-1:0] entry_address;
        logic [SIZE_W-1:0] entry_size;
    } t_cmd;

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [DATA_W-1:0] sample_address;
        logic [SIZE_W-1:0] sample_size;
        logic [DATA_W-1:0] elapsed_ticks;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [DATA_W-1:0] phase;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic              scan;
        logic [1:0]        status;
        logic [DATA_W-1:0] elapsed;
        logic [CNT_W-1:0]  count;
    } t_job;

    typedef struct packed {
        logic pop;
        logic scan_done;
    } t_back_ctl;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_LOAD,
        BS_DIVIDE,
        BS_FLUSH
    } t_bstate;

endpackage

// File: hw/rtl/periodic_sample_scheduler.sv
// Status transactions: queued, then result registered; one every cycle while queued.
// Tick: each table entry takes a table read, a load and a 32-step remainder unit, or
// just the read and load when the period is 0 or 1; busy stays high for the whole walk.
// Each result is shown for one cycle by o_result_valid; the receiver cannot stall.
// Synchronous active-low reset empties the table, stops sampling and clears start tick.
// ---------------------------------------------------------------------------
// Periodic sample scheduler
// Table of sampling entries with add, clear, start, stop and tick transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_sample_scheduler_defines.svh"

module periodic_sample_scheduler import pss_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_result_valid,
    output t_result o_result
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                    w_wr_en;
    logic [IDX_W-1:0]        w_wr_addr;
    t_entry                  w_wr_data;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [$bits(t_entry)-1:0] w_rd_bits;
    t_entry                  w_rd_entry;
    logic                    w_job_valid;
    t_job                    w_job;
    t_back_ctl               w_ctl;
    logic                    w_unknown_op;

    pss_front #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .o_busy     (busy),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_job_valid(w_job_valid),
        .o_job      (w_job),
        .i_ctl      (w_ctl)
    );

    pss_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_bits)
    );

    assign w_rd_entry = t_entry'(w_rd_bits);

    pss_back #(
        .IDX_W(IDX_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_ctl         (w_ctl),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_entry),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    assign w_unknown_op = start && !busy && (i_cmd.operation > OP_STOP);

    `PSS_ASSERT_IMP(a_sample_ok, o_result_valid && o_result.kind, o_result.status == ST_OK)
    `PSS_ASSERT_IMP(a_status_last, o_result_valid && !o_result.kind, o_result.last)
    `PSS_ASSERT_IMP(a_done_when_locked, w_ctl.scan_done, busy)
    `PSS_ASSERT_NXT(a_unknown_op_idle, w_unknown_op && !w_job_valid, !w_job_valid)

endmodule

// File: hw/rtl/pss_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/pss_front.sv
// ---------------------------------------------------------------------------
// Periodic sample scheduler front end
// Accepts transactions, keeps table count and run state, writes entries and
// queues jobs for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_front import pss_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_cmd             i_cmd,
    output logic             o_busy,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_addr,
    output t_entry           o_wr_data,
    output logic             o_job_valid,
    output t_job             o_job,
    input  t_back_ctl        i_ctl
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_running, n_running;
    logic [DATA_W-1:0] r_start_tick, n_start_tick;
    logic              r_lock, n_lock;
    t_job              r_q [Q_DEPTH];
    logic              r_q_wr, r_q_rd;
    logic [1:0]        r_q_cnt, n_q_cnt;
    logic              w_accept;
    logic              w_push;
    t_job              w_job;

    assign o_busy    = (r_q_cnt == 2'(Q_DEPTH)) || r_lock;
    assign w_accept  = i_start && !o_busy;
    assign o_wr_addr = r_count[IDX_W-1:0];
    assign o_wr_data = '{phase: i_cmd.entry_phase, period: i_cmd.entry_period,
                         address: i_cmd.entry_address, size: i_cmd.entry_size};

    always_comb begin
        n_count      = r_count;
        n_running    = r_running;
        n_start_tick = r_start_tick;
        w_push       = 1'b0;
        o_wr_en      = 1'b0;
        w_job        = '{scan: 1'b0, status: ST_OK, elapsed: '0, count: r_count};
        if (w_accept) begin
            case (i_cmd.operation)
                OP_TICK: begin
                    if (r_running) begin
                        w_push        = 1'b1;
                        w_job.scan    = 1'b1;
                        w_job.elapsed = i_cmd.tick_value - r_start_tick;
                    end
                end
                OP_ADD: begin
                    w_push = 1'b1;
                    if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                        w_job.status = ST_FULL;
                    end else begin
                        o_wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    w_push    = 1'b1;
                    n_running = 1'b0;
                    n_count   = '0;
                end
                OP_START: begin
                    w_push = 1'b1;
                    if (r_count == '0) begin
                        w_job.status = ST_EMPTY;
                    end else begin
                        n_running    = 1'b1;
                        n_start_tick = i_cmd.tick_value;
                    end
                end
                OP_STOP: begin
                    w_push    = 1'b1;
                    n_running = 1'b0;
                end
                default: begin
                    w_push = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_q_cnt = r_q_cnt + 2'(w_push) - 2'(i_ctl.pop);
        n_lock  = r_lock;
        if (i_ctl.scan_done) begin
            n_lock = 1'b0;
        end
        if (w_push && w_job.scan) begin
            n_lock = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_running    <= 1'b0;
            r_start_tick <= '0;
            r_lock       <= 1'b0;
            r_q_wr       <= 1'b0;
            r_q_rd       <= 1'b0;
            r_q_cnt      <= '0;
        end else begin
            r_count      <= n_count;
            r_running    <= n_running;
            r_start_tick <= n_start_tick;
            r_lock       <= n_lock;
            r_q_cnt      <= n_q_cnt;
            if (w_push) begin
                r_q_wr <= ~r_q_wr;
            end
            if (i_ctl.pop) begin
                r_q_rd <= ~r_q_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_q_wr] <= w_job;
        end
    end

    assign o_job_valid = (r_q_cnt != '0);
    assign o_job       = r_q[r_q_rd];

endmodule

// File: hw/rtl/pss_back.sv
// ---------------------------------------------------------------------------
// Periodic sample scheduler back end
// Delivers status replies and walks the table for tick jobs, testing each
// entry with a bit-serial remainder unit when its period exceeds 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pss_back import pss_pkg::*; #(
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output t_back_ctl        o_ctl,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_entry           i_rd_data,
    output logic             o_result_valid,
    output t_result          o_result
);

    t_bstate           r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_elapsed, n_elapsed;
    logic [DATA_W-1:0] r_dividend, n_dividend;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [4:0]        r_step, n_step;
    logic [DATA_W-1:0] r_period, n_period;
    logic [DATA_W-1:0] r_phase, n_phase;
    logic [DATA_W-1:0] r_cur_addr, n_cur_addr;
    logic [SIZE_W-1:0] r_cur_size, n_cur_size;
    logic              r_pend_v, n_pend_v;
    logic [DATA_W-1:0] r_pend_addr, n_pend_addr;
    logic [SIZE_W-1:0] r_pend_size, n_pend_size;
    logic              r_out_v, n_out_v;
    t_result           r_out, n_out;
    logic [DATA_W:0]   w_trial;
    logic              w_ge;
    logic [DATA_W-1:0] w_rem_next;
    logic              w_last_entry;
    logic              w_decide;
    logic              w_hit;

    assign w_trial      = {r_rem, r_dividend[DATA_W-1]};
    assign w_ge         = w_trial >= {1'b0, r_period};
    assign w_rem_next   = w_ge ? DATA_W'(w_trial - {1'b0, r_period}) : w_trial[DATA_W-1:0];
    assign w_last_entry = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign o_rd_addr    = r_idx;

    always_comb begin
        w_decide = 1'b0;
        w_hit    = 1'b0;
        if (r_state == BS_LOAD && i_rd_data.period <= DATA_W'(1)) begin
            w_decide = 1'b1;
            w_hit    = (i_rd_data.period == DATA_W'(1));
        end else if (r_state == BS_DIVIDE && r_step == 5'(DATA_W - 1)) begin
            w_decide = 1'b1;
            w_hit    = (w_rem_next == r_phase);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_job_valid && i_job.scan && i_job.count != '0) begin
                    n_state = BS_READ;
                end
            end
            BS_READ: begin
                n_state = BS_LOAD;
            end
            BS_LOAD, BS_DIVIDE: begin
                if (w_decide) begin
                    n_state = w_last_entry ? BS_FLUSH : BS_READ;
                end else begin
                    n_state = BS_DIVIDE;
                end
            end
            BS_FLUSH: begin
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_count     = r_count;
        n_elapsed   = r_elapsed;
        n_dividend  = r_dividend;
        n_rem       = r_rem;
        n_step      = r_step;
        n_period    = r_period;
        n_phase     = r_phase;
        n_cur_addr  = r_cur_addr;
        n_cur_size  = r_cur_size;
        n_pend_v    = r_pend_v;
        n_pend_addr = r_pend_addr;
        n_pend_size = r_pend_size;
        n_out_v     = 1'b0;
        n_out       = r_out;
        o_ctl.pop       = 1'b0;
        o_ctl.scan_done = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_job_valid) begin
                    o_ctl.pop = 1'b1;
                    if (i_job.scan) begin
                        n_idx     = '0;
                        n_count   = i_job.count;
                        n_elapsed = i_job.elapsed;
                        n_pend_v  = 1'b0;
                        o_ctl.scan_done = (i_job.count == '0);
                    end else begin
                        n_out_v = 1'b1;
                        n_out   = '{kind: KIND_STATUS, status: i_job.status,
                                    sample_address: '0, sample_size: '0,
                                    elapsed_ticks: '0, last: 1'b1};
                    end
                end
            end
            BS_LOAD: begin
                n_period   = i_rd_data.period;
                n_phase    = i_rd_data.phase;
                n_cur_addr = i_rd_data.address;
                n_cur_size = i_rd_data.size;
                n_dividend = r_elapsed;
                n_rem      = '0;
                n_step     = '0;
            end
            BS_DIVIDE: begin
                n_rem      = w_rem_next;
                n_dividend = {r_dividend[DATA_W-2:0], 1'b0};
                n_step     = r_step + 5'd1;
            end
            BS_FLUSH: begin
                o_ctl.scan_done = 1'b1;
                if (r_pend_v) begin
                    n_out_v = 1'b1;
                    n_out   = '{kind: KIND_SAMPLE, status: ST_OK,
                                sample_address: r_pend_addr, sample_size: r_pend_size,
                                elapsed_ticks: r_elapsed, last: 1'b1};
                end
            end
            default: begin
                n_out_v = 1'b0;
            end
        endcase
        if (w_decide) begin
            if (w_hit) begin
                if (r_pend_v) begin
                    n_out_v = 1'b1;
                    n_out   = '{kind: KIND_SAMPLE, status: ST_OK,
                                sample_address: r_pend_addr, sample_size: r_pend_size,
                                elapsed_ticks: r_elapsed, last: 1'b0};
                end
                n_pend_v    = 1'b1;
                n_pend_addr = (r_state == BS_LOAD) ? i_rd_data.address : r_cur_addr;
                n_pend_size = (r_state == BS_LOAD) ? i_rd_data.size : r_cur_size;
            end
            if (!w_last_entry) begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_count     <= n_count;
        r_elapsed   <= n_elapsed;
        r_dividend  <= n_dividend;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_period    <= n_period;
        r_phase     <= n_phase;
        r_cur_addr  <= n_cur_addr;
        r_cur_size  <= n_cur_size;
        r_pend_addr <= n_pend_addr;
        r_pend_size <= n_pend_size;
        r_out       <= n_out;
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

endmodule
